// ===== hw/rtl/newell_polygon_normal_core_macros.svh =====
// assertion macros for the checker file
`ifndef NEWELL_POLYGON_NORMAL_CORE_MACROS_SVH
`define NEWELL_POLYGON_NORMAL_CORE_MACROS_SVH

// clocked assertion with no reset qualifier
`define NPN_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion that is quiet while reset is high
`define NPN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== hw/rtl/npn_pkg.sv =====
// shared types and constants of the polygon normal block
package npn_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_W      = 16;
   localparam int SUM_W        = 42;
   localparam int PROD_W       = 34;
   localparam int NORM_W       = 16;
   localparam int SHMAG_W      = 31;
   localparam int SQ_W         = 64;
   localparam int LEN_W        = 32;
   localparam int NUM_W        = 48;
   localparam int Q_DEPTH      = 2;
   localparam int Q_PTR_W      = $clog2(Q_DEPTH);

   localparam logic [NORM_W-1:0] Q14_ONE = 16'd16384;

   // sum saturation limit: min(MAX_VERTICES * 2^32, 2^41 - 1)
   localparam logic [63:0] LIM_BY_COUNT = 64'(MAX_VERTICES) << 32;
   localparam logic [63:0] LIM_BY_WIDTH = (64'd1 << (SUM_W - 1)) - 64'd1;
   localparam logic [63:0] SUM_LIM_WIDE =
      (LIM_BY_COUNT < LIM_BY_WIDTH) ? LIM_BY_COUNT : LIM_BY_WIDTH;
   localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_LIM_WIDE[SUM_W-1:0];

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } sum_vec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_ACC,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SHIFT,
      B_SQ,
      B_SQRT,
      B_DIVLD,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage

// ===== hw/rtl/npn_chan_if.sv =====
// valid/ready channel interfaces for vertex items and normal items
interface npn_req_if;
   import npn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;
   logic signed [COORD_W-1:0] z_coord;
   logic                      last_vertex;

   modport source (output valid, x_coord, y_coord, z_coord, last_vertex, input ready);
   modport sink   (input valid, x_coord, y_coord, z_coord, last_vertex, output ready);
endinterface

interface npn_rsp_if;
   import npn_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [NORM_W-1:0] normal_x;
   logic signed [NORM_W-1:0] normal_y;
   logic signed [NORM_W-1:0] normal_z;
   logic                     degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== hw/rtl/npn_front.sv =====
// vertex intake and Newell cross-term accumulation
module npn_front (
   input  logic                 clock,
   input  logic                 reset,
   npn_req_if.sink              req_ch,
   output logic                 q_push,
   output npn_pkg::sum_vec_type q_data,
   input  npn_pkg::q_stat_type  q_stat
);
   import npn_pkg::*;

   localparam logic signed [SUM_W:0] LIM_EXT = {1'b0, SUM_LIM};

   front_state_type  state_ff, state_in;
   logic             in_poly_ff;
   logic             last_ff;
   logic             closing_ff;
   vertex_type       first_ff, prev_ff, cur_ff;
   vertex_type       va, vb, vin;
   sum_vec_type      sum_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in;
   logic signed [COORD_W:0]  dx, dy, dz, sx, sy, sz;
   logic             req_fire;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]  acc,
      input logic signed [PROD_W-1:0] term);
      logic signed [SUM_W:0] r;
      r = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - PROD_W){term[PROD_W-1]}}, term};
      if (r > LIM_EXT) begin
         r = LIM_EXT;
      end else if (r < -LIM_EXT) begin
         r = -LIM_EXT;
      end
      return r[SUM_W-1:0];
   endfunction

   assign req_fire = req_ch.valid && req_ch.ready;
   assign vin      = '{x: req_ch.x_coord, y: req_ch.y_coord, z: req_ch.z_coord};

   // edge operands: running edge, or closing edge back to the first vertex
   always_comb begin
      va    = prev_ff;
      vb    = closing_ff ? first_ff : cur_ff;
      dx    = {va.x[COORD_W-1], va.x} - {vb.x[COORD_W-1], vb.x};
      dy    = {va.y[COORD_W-1], va.y} - {vb.y[COORD_W-1], vb.y};
      dz    = {va.z[COORD_W-1], va.z} - {vb.z[COORD_W-1], vb.z};
      sx    = {va.x[COORD_W-1], va.x} + {vb.x[COORD_W-1], vb.x};
      sy    = {va.y[COORD_W-1], va.y} + {vb.y[COORD_W-1], vb.y};
      sz    = {va.z[COORD_W-1], va.z} + {vb.z[COORD_W-1], vb.z};
      px_in = dy * sz;
      py_in = dz * sx;
      pz_in = dx * sy;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_fire) begin
               if (!in_poly_ff) begin
                  state_in = req_ch.last_vertex ? F_MUL : F_IDLE;
               end else begin
                  state_in = F_MUL;
               end
            end
         end
         F_MUL: state_in = F_ACC;
         F_ACC: begin
            if (closing_ff) begin
               state_in = F_PUSH;
            end else if (last_ff) begin
               state_in = F_MUL;
            end else begin
               state_in = F_IDLE;
            end
         end
         F_PUSH: state_in = q_stat.full ? F_PUSH : F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready = 1'b0;
      q_push       = 1'b0;
      case (state_ff)
         F_IDLE:  req_ch.ready = 1'b1;
         F_PUSH:  q_push       = !q_stat.full;
         default: begin
            req_ch.ready = 1'b0;
            q_push       = 1'b0;
         end
      endcase
   end

   assign q_data = sum_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         in_poly_ff <= 1'b0;
         closing_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            F_IDLE: begin
               if (req_fire) begin
                  last_ff    <= req_ch.last_vertex;
                  closing_ff <= !in_poly_ff;
                  in_poly_ff <= 1'b1;
               end
            end
            F_ACC: begin
               if (!closing_ff && last_ff) begin
                  closing_ff <= 1'b1;
               end
            end
            F_PUSH: begin
               if (!q_stat.full) begin
                  in_poly_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // vertex, product and sum datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (req_fire) begin
               cur_ff <= vin;
               if (!in_poly_ff) begin
                  first_ff <= vin;
                  prev_ff  <= vin;
                  sum_ff   <= '0;
               end
            end
         end
         F_MUL: begin
            px_ff <= px_in;
            py_ff <= py_in;
            pz_ff <= pz_in;
         end
         F_ACC: begin
            sum_ff.x <= sat_add(sum_ff.x, px_ff);
            sum_ff.y <= sat_add(sum_ff.y, py_ff);
            sum_ff.z <= sat_add(sum_ff.z, pz_ff);
            if (!closing_ff) begin
               prev_ff <= cur_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/npn_fifo.sv =====
// short queue of finished sums between accumulation and normalization
module npn_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  npn_pkg::sum_vec_type push_data,
   input  logic                 pop,
   output npn_pkg::sum_vec_type pop_data,
   output npn_pkg::q_stat_type  q_stat
);
   import npn_pkg::*;

   sum_vec_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff;
   logic [Q_PTR_W-1:0]  rd_ptr_ff;
   logic [Q_PTR_W:0]    count_ff;

   assign q_stat.full  = count_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/npn_back.sv =====
// normalization: scale, sum of squares, square root and three divisions
module npn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  npn_pkg::q_stat_type  q_stat,
   output logic                 pop,
   input  npn_pkg::sum_vec_type pop_data,
   npn_rsp_if.source            rsp_ch
);
   import npn_pkg::*;

   back_state_type state_ff, state_in;
   logic [SUM_W-1:0]        mag_ff [3];
   logic [2:0]              neg_ff;
   logic [SQ_W-1:0]         sq_ff, sqp_ff;
   logic [SQ_W-1:0]         v_ff, res_ff, bit_ff;
   logic [SQ_W-1:0]         sq_trial, res_nx;
   logic                    sq_ge;
   logic [LEN_W-1:0]        len_ff;
   logic [NUM_W-1:0]        rem_ff, div_trial;
   logic [NORM_W-1:0]       q_ff, q_nx, q_clamp;
   logic [4:0]              cnt_ff;
   logic [1:0]              idx_ff;
   logic signed [NORM_W-1:0] nrm_ff [3];
   logic                    degen_ff;
   logic [SUM_W-1:0]        m_or;
   logic [5:0]              top;
   logic [3:0]              sh;
   logic [SHMAG_W-1:0]      mag_sel;
   logic                    div_ge;

   // magnitude leading bit sets the pre-scale shift
   always_comb begin
      m_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      top  = '0;
      for (int i = 0; i < SUM_W; i++) begin
         if (m_or[i]) begin
            top = 6'(i);
         end
      end
      sh = (top >= 6'(SHMAG_W)) ? 4'(top - 6'(SHMAG_W - 1)) : 4'd0;
   end

   assign mag_sel = mag_ff[idx_ff][SHMAG_W-1:0];

   // one square root step
   always_comb begin
      sq_trial = res_ff + bit_ff;
      sq_ge    = v_ff >= sq_trial;
      res_nx   = sq_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   end

   // one restoring division step
   always_comb begin
      div_trial = NUM_W'(len_ff) << cnt_ff[3:0];
      div_ge    = rem_ff >= div_trial;
      q_nx      = div_ge ? (q_ff | (NORM_W'(1) << cnt_ff[3:0])) : q_ff;
      q_clamp   = (q_nx > Q14_ONE) ? Q14_ONE : q_nx;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  state_in = q_stat.empty ? B_IDLE : B_SHIFT;
         B_SHIFT: state_in = (m_or == '0) ? B_OUT : B_SQ;
         B_SQ:    state_in = (cnt_ff == 5'd3) ? B_SQRT : B_SQ;
         B_SQRT:  state_in = (cnt_ff == 5'd31) ? B_DIVLD : B_SQRT;
         B_DIVLD: state_in = B_DIV;
         B_DIV: begin
            if (cnt_ff == '0) begin
               state_in = (idx_ff == 2'd2) ? B_OUT : B_DIVLD;
            end
         end
         B_OUT:   state_in = rsp_ch.ready ? B_IDLE : B_OUT;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop          = 1'b0;
      rsp_ch.valid = 1'b0;
      case (state_ff)
         B_IDLE:  pop          = !q_stat.empty;
         B_OUT:   rsp_ch.valid = 1'b1;
         default: begin
            pop          = 1'b0;
            rsp_ch.valid = 1'b0;
         end
      endcase
   end

   assign rsp_ch.normal_x   = nrm_ff[0];
   assign rsp_ch.normal_y   = nrm_ff[1];
   assign rsp_ch.normal_z   = nrm_ff[2];
   assign rsp_ch.degenerate = degen_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            mag_ff[0] <= pop_data.x[SUM_W-1] ? SUM_W'(-pop_data.x) : SUM_W'(pop_data.x);
            mag_ff[1] <= pop_data.y[SUM_W-1] ? SUM_W'(-pop_data.y) : SUM_W'(pop_data.y);
            mag_ff[2] <= pop_data.z[SUM_W-1] ? SUM_W'(-pop_data.z) : SUM_W'(pop_data.z);
            neg_ff    <= {pop_data.z[SUM_W-1], pop_data.y[SUM_W-1], pop_data.x[SUM_W-1]};
         end
         B_SHIFT: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_ff[i] >> sh;
               nrm_ff[i] <= '0;
            end
            degen_ff <= m_or == '0;
            sq_ff    <= '0;
            cnt_ff   <= '0;
            idx_ff   <= '0;
         end
         B_SQ: begin
            // multiply one component per cycle, add it the cycle after
            if (cnt_ff != '0) begin
               sq_ff <= sq_ff + sqp_ff;
            end
            if (cnt_ff != 5'd3) begin
               sqp_ff <= SQ_W'(mag_sel) * SQ_W'(mag_sel);
               idx_ff <= idx_ff + 2'd1;
            end else begin
               v_ff   <= sq_ff + sqp_ff;
               res_ff <= '0;
               bit_ff <= SQ_W'(1) << (SQ_W - 2);
               idx_ff <= '0;
            end
            cnt_ff <= (cnt_ff == 5'd3) ? 5'd0 : cnt_ff + 5'd1;
         end
         B_SQRT: begin
            if (sq_ge) begin
               v_ff <= v_ff - sq_trial;
            end
            res_ff <= res_nx;
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               len_ff <= (res_nx[LEN_W-1:0] == '0) ? LEN_W'(1) : res_nx[LEN_W-1:0];
            end
         end
         B_DIVLD: begin
            rem_ff <= (NUM_W'(mag_sel) << 14) + NUM_W'(len_ff >> 1);
            q_ff   <= '0;
            cnt_ff <= 5'd15;
         end
         B_DIV: begin
            if (div_ge) begin
               rem_ff <= rem_ff - div_trial;
            end
            q_ff   <= q_nx;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               nrm_ff[idx_ff] <= neg_ff[idx_ff] ? -$signed(q_clamp) : $signed(q_clamp);
               idx_ff         <= idx_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/newell_polygon_normal_core.sv =====
// polygon normal core: Newell sums over a vertex stream, unit normal per polygon
//
// req_ch carries one vertex per item (Q8.8 x, y, z and a last-vertex mark).
// rsp_ch carries one item per polygon: the unit normal in Q1.14 and a flag
// that is set, with a zero normal, when the summed vector has zero length.
// The front takes a vertex in F_IDLE and runs its edge through F_MUL and
// F_ACC before it takes the next; an opening vertex that is not the last
// is only stored. After the last vertex it runs F_MUL and F_ACC for the
// closing edge, then hands the sums to a two-entry queue in F_PUSH.
// The back normalizes one polygon at a time: one scale step, the sum of
// squares on one multiplier, 32 square root steps, then three 16-step
// divisions, one quotient bit per cycle; a zero sum skips to the output.
// A result stays on rsp_ch until taken, and only then does the back pop;
// the front takes vertices until a push finds the queue full, then holds req_ch.ready low.
// Reset (synchronous, active high) empties the queue, drops any result and
// makes the next vertex open a new polygon.
module newell_polygon_normal_core (
   input logic       clock,
   input logic       reset,
   npn_req_if.sink   req_ch,
   npn_rsp_if.source rsp_ch
);
   import npn_pkg::*;

   logic        q_push;
   logic        q_pop;
   sum_vec_type q_push_data;
   sum_vec_type q_pop_data;
   q_stat_type  q_stat;

   // vertex intake and accumulation
   npn_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_push (q_push),
      .q_data (q_push_data),
      .q_stat (q_stat)
   );

   // queue of finished sums
   npn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_stat    (q_stat)
   );

   // normalization
   npn_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== hw/rtl/npn_checker.sv =====
// port-level checks on the result channel, bound to the top level
`include "newell_polygon_normal_core_macros.svh"

module npn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [15:0] normal_x,
   input logic signed [15:0] normal_y,
   input logic signed [15:0] normal_z,
   input logic        degenerate
);

   // no result right after reset
   `NPN_ASSERT_CLK(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   // a degenerate result carries a zero normal
   `NPN_ASSERT(a_degen_zero, rsp_valid && degenerate |-> normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0, "degenerate result with nonzero normal")

   // a real normal has some nonzero component
   `NPN_ASSERT(a_nondegen_nonzero, rsp_valid && !degenerate |-> normal_x != 16'sd0 || normal_y != 16'sd0 || normal_z != 16'sd0, "zero normal without degenerate flag")

   // components stay within unit range
   `NPN_ASSERT(a_unit_range, rsp_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 && normal_y <= 16'sd16384 && normal_y >= -16'sd16384 && normal_z <= 16'sd16384 && normal_z >= -16'sd16384, "normal component out of range")

   // a stalled result holds
   `NPN_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(degenerate), "stalled result changed")

endmodule

bind newell_polygon_normal_core npn_checker u_npn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .normal_x   (rsp_ch.normal_x),
   .normal_y   (rsp_ch.normal_y),
   .normal_z   (rsp_ch.normal_z),
   .degenerate (rsp_ch.degenerate)
);
